// ===== rtl/fir_pkg.sv =====
// fir_pkg: shared types and constants for the 64-tap q15 fir filter
// used by fir_tap_cell, fir_mac and fir_filter_q15_64tap; no dependencies
package fir_pkg;

  // sample and coefficient width, q15 shift
  localparam int unsigned DataW  = 16;
  localparam int unsigned IndexW = 6;
  localparam int unsigned AccW   = 32;
  localparam int unsigned QShift = 15;

  // request kind carried on tuser
  localparam logic ReqSample = 1'b0;
  localparam logic ReqCoef   = 1'b1;

  // controller states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } fir_state_e;

  // controls broadcast to every cell of the chain
  typedef struct packed {
    logic shift;   // insert a new sample at the head, oldest falls out
    logic rotate;  // turn the whole ring one step toward the head
    logic load;    // write a coefficient at the matching tap
  } cell_ctrl_t;

  // controls for the multiply-accumulate unit
  typedef struct packed {
    logic clear;   // start of a new output word
    logic valid;   // head cell holds a tap that counts
    logic half_b;  // tap belongs to the second half
  } mac_ctrl_t;

endpackage

// ===== rtl/fir_filter_q15_64tap.sv =====
// fir_filter_q15_64tap: a sample item is filtered one tap per cycle through the single
// shared multiplier as the ring rotates, then the result goes to the output register.
// a new sample is taken once the previous result sits in the output register,
// so samples do not overlap; a coefficient load leaves the block ready for the next item.
// asynchronous active-low reset clears delay line, coefficients and control.
// depends on fir_pkg, fir_tap_cell, fir_mac
module fir_filter_q15_64tap #(
  parameter int unsigned TAPS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // sample_in[15:0], coef_index[21:16], coef_value[37:22]
  input  logic        s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // filtered_out[15:0]
);
  import fir_pkg::*;

  localparam int unsigned KW   = $clog2(TAPS) + 1;
  localparam int unsigned Half = TAPS / 2;

  fir_state_e           state_q, state_d;
  logic [KW-1:0]        k_q, k_d;
  logic                 accept;
  logic                 req_type;
  logic signed [DataW-1:0] sample_in;
  logic [IndexW-1:0]    coef_index;
  logic signed [DataW-1:0] coef_value;
  cell_ctrl_t           cell_ctrl;
  mac_ctrl_t            mac_ctrl;
  logic [DataW-1:0]     sum;
  logic                 out_valid_q;
  logic [DataW-1:0]     out_data_q;
  logic                 out_load;

  logic signed [DataW-1:0] x_w [TAPS];
  logic signed [DataW-1:0] c_w [TAPS];

  // unpack the input word
  assign req_type   = s_axis_tuser;
  assign sample_in  = s_axis_tdata[15:0];
  assign coef_index = s_axis_tdata[21:16];
  assign coef_value = s_axis_tdata[37:22];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

  // controller
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && req_type == ReqSample) begin
          state_d = ST_RUN;
          k_d     = '0;
        end
      end
      ST_RUN: begin
        k_d = k_q + 1'b1;
        if (k_q == KW'(TAPS - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  // chain and mac controls
  always_comb begin
    cell_ctrl.shift  = accept && (req_type == ReqSample);
    cell_ctrl.load   = accept && (req_type == ReqCoef);
    cell_ctrl.rotate = (state_q == ST_RUN);
    mac_ctrl.clear   = cell_ctrl.shift;
    mac_ctrl.half_b  = (k_q >= KW'(Half));
    mac_ctrl.valid   = (state_q == ST_RUN) && (k_q < KW'(2 * Half));
  end

  // ring of tap cells, head is cell 0
  for (genvar i = 0; i < TAPS; i++) begin : g_cell
    localparam int unsigned Prev = (i == 0) ? 0 : i - 1;
    localparam int unsigned Next = (i + 1) % TAPS;
    logic signed [DataW-1:0] shift_src;

    assign shift_src = (i == 0) ? sample_in : x_w[Prev];

    fir_tap_cell #(
      .Idx(i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl),
      .shift_x_i    (shift_src),
      .rot_x_i      (x_w[Next]),
      .rot_c_i      (c_w[Next]),
      .coef_index_i (coef_index),
      .coef_value_i (coef_value),
      .x_o          (x_w[i]),
      .c_o          (c_w[i])
    );
  end

  fir_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .x_i    (x_w[0]),
    .c_i    (c_w[0]),
    .sum_o  (sum)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= sum;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== rtl/fir_tap_cell.sv =====
// fir_tap_cell: one tap of the ring, holding a delayed sample and its coefficient
// depends on fir_pkg
module fir_tap_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fir_pkg::cell_ctrl_t                 ctrl_i,
  input  logic signed [fir_pkg::DataW-1:0]    shift_x_i,
  input  logic signed [fir_pkg::DataW-1:0]    rot_x_i,
  input  logic signed [fir_pkg::DataW-1:0]    rot_c_i,
  input  logic        [fir_pkg::IndexW-1:0]   coef_index_i,
  input  logic signed [fir_pkg::DataW-1:0]    coef_value_i,
  output logic signed [fir_pkg::DataW-1:0]    x_o,
  output logic signed [fir_pkg::DataW-1:0]    c_o
);
  import fir_pkg::*;

  logic signed [DataW-1:0] x_q, x_d;
  logic signed [DataW-1:0] c_q, c_d;
  logic                    hit;

  // tap select for coefficient loads; indexes past the chain match nothing
  assign hit = (32'(coef_index_i) == 32'(Idx));

  // next sample and coefficient
  always_comb begin
    x_d = x_q;
    c_d = c_q;
    if (ctrl_i.rotate) begin
      x_d = rot_x_i;
      c_d = rot_c_i;
    end else if (ctrl_i.shift) begin
      x_d = shift_x_i;
    end else if (ctrl_i.load && hit) begin
      c_d = coef_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      c_q <= '0;
    end else begin
      x_q <= x_d;
      c_q <= c_d;
    end
  end

  assign x_o = x_q;
  assign c_o = c_q;

endmodule

// ===== rtl/fir_mac.sv =====
// fir_mac: shared multiplier with a registered product and two half accumulators
// depends on fir_pkg
module fir_mac (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fir_pkg::mac_ctrl_t                ctrl_i,
  input  logic signed [fir_pkg::DataW-1:0]  x_i,
  input  logic signed [fir_pkg::DataW-1:0]  c_i,
  output logic        [fir_pkg::DataW-1:0]  sum_o
);
  import fir_pkg::*;

  logic signed [AccW-1:0] prod_d, prod_q;
  logic                   pvalid_q;
  logic                   phalf_q;
  logic        [AccW-1:0] acc_a_q, acc_b_q;
  logic        [DataW-1:0] half_a, half_b;

  // sign-extend both operands first so the full 32-bit product is kept
  assign prod_d = AccW'(x_i) * AccW'(c_i);

  // product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvalid_q <= 1'b0;
      phalf_q  <= 1'b0;
    end else begin
      pvalid_q <= ctrl_i.valid;
      phalf_q  <= ctrl_i.half_b;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // accumulate stage, 32-bit wraparound
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_a_q <= '0;
      acc_b_q <= '0;
    end else if (ctrl_i.clear) begin
      acc_a_q <= '0;
      acc_b_q <= '0;
    end else if (pvalid_q) begin
      if (phalf_q) begin
        acc_b_q <= acc_b_q + AccW'(prod_q);
      end else begin
        acc_a_q <= acc_a_q + AccW'(prod_q);
      end
    end
  end

  // arithmetic shift by 15 then keep 16 bits of each half, add with wrap
  assign half_a = acc_a_q[QShift +: DataW];
  assign half_b = acc_b_q[QShift +: DataW];
  assign sum_o  = half_a + half_b;

endmodule
